>>> design/salc_pkg.sv
// Shared types and constants of the set-associative LRU hit tracker.
// No dependencies; every other design file but salc_ram refers to this package by scoped names.
package salc_pkg;

  localparam int LINE_BYTES = 32;
  localparam int LINE_SHIFT = 5;
  localparam int MAX_WAYS   = 16;
  localparam int WAYS_LOG2  = 4;
  localparam int PADDR_W    = 4;

  localparam logic [1:0] REG_CACHE_SIZE = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_STORE_ALLOC = 2'd2;
  localparam logic [1:0] REG_PREFETCH   = 2'd3;

  localparam logic [1:0] PF_NONE  = 2'd0;
  localparam logic [1:0] PF_EVERY = 2'd1;
  localparam logic [1:0] PF_MISS  = 2'd2;

  localparam logic CMD_STORE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
  } in_beat_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_count;
    logic [31:0] access_count;
  } out_beat_t;

  typedef struct packed {
    logic [3:0] cache_size_log2;
    logic [2:0] ways_log2;
    logic       store_miss_allocate;
    logic [1:0] prefetch_mode;
  } cfg_t;

  typedef struct packed {
    logic accept;    // capture the input beat and read its set row
    logic rd_pf;     // read the set row of the next line
    logic ev_demand; // update the demand set and the counts
    logic ev_pf;     // update the prefetch set
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic do_pf;     // prefetch needed after this demand probe
  } dp_status_t;

endpackage

>>> design/set_assoc_lru_cache_hit_tracker.sv
// Top level of the set-associative LRU hit tracker: register port, sequencer, datapath.
// Depends on salc_pkg, salc_ctrl, salc_dp (and salc_ram through salc_dp).
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one beat per load or
//   store address. The output channel (out_valid_o / out_stall_i / out_data_o)
//   returns one beat per input beat: the demand hit flag plus the saturating
//   hit and access counts after that access.
//   Each item steps through accept, demand probe, optional prefetch probe and
//   result load; in_stall_o stays high until the sequencer is back in idle.
//   Each probe is one read-modify-write of a whole set row in the tag RAM (one
//   read port, one write port, registered read), so one item holds at most two
//   RAM round trips. The result register lets the next beat be accepted while a
//   finished result still waits; once a result is pending and stalled the
//   following item completes its probes and then holds until the slot frees.
//   Reset clears the sequencer, the counts and one valid flag per RAM row, so
//   no clearing pass is needed and a beat is taken in the first cycle after
//   reset. A write to the cache size or ways register clears the row flags the
//   same way; counts are kept. Write registers only while the block is idle.
//   Registers sit at byte addresses 0, 4, 8, 12 of the APB port.
module set_assoc_lru_cache_hit_tracker #(
  parameter int MAX_LINES = 1024,
  parameter int ADDR_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  salc_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output salc_pkg::out_beat_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  salc_pkg::cfg_t       cfg_q;
  salc_pkg::ctrl_cmd_t  cmd;
  salc_pkg::dp_status_t status;
  logic                 wr_en, clr;
  logic [1:0]           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  // Any geometry write empties the cache
  assign clr     = wr_en && (reg_idx == salc_pkg::REG_CACHE_SIZE
                          || reg_idx == salc_pkg::REG_WAYS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cache_size_log2     <= 4'd14;
      cfg_q.ways_log2           <= 3'd1;
      cfg_q.store_miss_allocate <= 1'b1;
      cfg_q.prefetch_mode       <= salc_pkg::PF_NONE;
    end else if (wr_en) begin
      case (reg_idx)
        salc_pkg::REG_CACHE_SIZE:  cfg_q.cache_size_log2     <= pwdata[3:0];
        salc_pkg::REG_WAYS:        cfg_q.ways_log2           <= pwdata[2:0];
        salc_pkg::REG_STORE_ALLOC: cfg_q.store_miss_allocate <= pwdata[0];
        salc_pkg::REG_PREFETCH:    cfg_q.prefetch_mode       <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      salc_pkg::REG_CACHE_SIZE:  prdata = {28'd0, cfg_q.cache_size_log2};
      salc_pkg::REG_WAYS:        prdata = {29'd0, cfg_q.ways_log2};
      salc_pkg::REG_STORE_ALLOC: prdata = {31'd0, cfg_q.store_miss_allocate};
      salc_pkg::REG_PREFETCH:    prdata = {30'd0, cfg_q.prefetch_mode};
      default:                   prdata = '0;
    endcase
  end

  // Sequencer: accept, demand probe, optional prefetch probe, result
  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Tag RAM, LRU update and counts
  salc_dp #(
    .MAX_LINES (MAX_LINES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clr_i      (clr),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

>>> design/salc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/salc_ctrl.sv
// Sequencer of the hit tracker: handshakes and the probe steps of one item.
// Depends on salc_pkg.
module salc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  salc_pkg::dp_status_t   status_i,
  output salc_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EV1  = 3'd1;
  localparam logic [2:0] ST_RD2  = 3'd2;
  localparam logic [2:0] ST_EV2  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EV1;
        end
      end
      ST_EV1: begin
        cmd_o.ev_demand = 1'b1;
        state_d         = status_i.do_pf ? ST_RD2 : ST_DONE;
      end
      ST_RD2: begin
        cmd_o.rd_pf = 1'b1;
        state_d     = ST_EV2;
      end
      ST_EV2: begin
        cmd_o.ev_pf = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/salc_dp.sv
// Datapath of the hit tracker: geometry, set rows in RAM, LRU update, counts.
// Depends on salc_pkg and salc_ram.
module salc_dp #(
  parameter int MAX_LINES = 1024,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  salc_pkg::cfg_t       cfg_i,
  input  logic                 clr_i,
  input  salc_pkg::in_beat_t   in_data_i,
  input  salc_pkg::ctrl_cmd_t  cmd_i,
  output salc_pkg::dp_status_t status_o,
  output salc_pkg::out_beat_t  out_data_o
);

  localparam int LINES_LOG2 = $clog2(MAX_LINES);
  localparam int NROWS      = MAX_LINES / salc_pkg::MAX_WAYS;
  localparam int ROW_W      = $clog2(NROWS);
  localparam int TAG_W      = ADDR_BITS - salc_pkg::LINE_SHIFT;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [3:0]       rank;
  } entry_t;

  typedef entry_t [salc_pkg::MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [3:0]       slot;
    logic [TAG_W-1:0] tag;
  } loc_t;

  // Geometry
  logic [3:0] csz, lines_log2, sets_log2;
  logic [2:0] wl_c;
  logic [3:0] wl;

  always_comb begin
    csz = cfg_i.cache_size_log2;
    if (csz < 4'd10) csz = 4'd10;
    if (csz > 4'd15) csz = 4'd15;
    lines_log2 = csz - 4'(salc_pkg::LINE_SHIFT);
    if (lines_log2 > 4'(LINES_LOG2)) lines_log2 = 4'(LINES_LOG2);
    wl_c = (cfg_i.ways_log2 > 3'd4) ? 3'd4 : cfg_i.ways_log2;
    wl   = {1'b0, wl_c};
    if (wl > 4'(salc_pkg::WAYS_LOG2)) wl = 4'(salc_pkg::WAYS_LOG2);
    if (wl > lines_log2) wl = lines_log2;
    sets_log2 = lines_log2 - wl;
  end

  function automatic loc_t loc_of(input logic [ADDR_BITS-1:0] a,
                                  input logic [3:0] s_log2,
                                  input logic [3:0] w_log2);
    logic [LINES_LOG2-1:0] set_idx, base;
    loc_t                  l;
    set_idx = LINES_LOG2'(a >> salc_pkg::LINE_SHIFT)
            & ((LINES_LOG2'(1) << s_log2) - LINES_LOG2'(1));
    base    = set_idx << w_log2;
    l.row   = base[LINES_LOG2-1:salc_pkg::WAYS_LOG2];
    l.slot  = base[salc_pkg::WAYS_LOG2-1:0];
    l.tag   = TAG_W'(a >> (5'(salc_pkg::LINE_SHIFT) + {1'b0, s_log2}));
    return l;
  endfunction

  // Item registers
  logic                 cmd_q;
  logic [ADDR_BITS-1:0] addr_q, pf_addr, in_addr;
  logic                 hit_q;
  logic [31:0]          hits_q, acc_q;
  salc_pkg::out_beat_t  out_q;

  assign in_addr = ADDR_BITS'(in_data_i.address);
  assign pf_addr = addr_q + ADDR_BITS'(salc_pkg::LINE_BYTES);

  // Set rows
  logic [NROWS-1:0] row_valid_q;
  logic             rv_q;
  loc_t             rd_loc, ev_loc;
  logic [ROW_W-1:0] raddr;
  row_t             rdata, row_in, row_out;
  logic             we;

  assign rd_loc = cmd_i.rd_pf ? loc_of(pf_addr, sets_log2, wl)
                              : loc_of(in_addr, sets_log2, wl);
  assign raddr  = rd_loc.row;
  assign ev_loc = cmd_i.ev_pf ? loc_of(pf_addr, sets_log2, wl)
                              : loc_of(addr_q, sets_log2, wl);

  salc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ev_loc.row),
    .wdata_i (row_out),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Probe evaluation over the ways of the set in the row
  logic [salc_pkg::MAX_WAYS-1:0] active, match, inval, is_max;
  logic [3:0] wmask, hw, iw, mw, tw;
  logic       hit, any_inv, may_fill, ev;
  logic [4:0] old_rank;

  always_comb begin
    row_in = rv_q ? rdata : '0;
    wmask  = (4'd1 << wl) - 4'd1;
    for (int s = 0; s < salc_pkg::MAX_WAYS; s++) begin
      active[s] = ((4'(s) & ~wmask) == (ev_loc.slot & ~wmask));
      match[s]  = active[s] && row_in[s].valid && (row_in[s].tag == ev_loc.tag);
      inval[s]  = active[s] && !row_in[s].valid;
      is_max[s] = active[s];
      for (int v = 0; v < salc_pkg::MAX_WAYS; v++) begin
        if (active[v] && (row_in[v].rank > row_in[s].rank)) is_max[s] = 1'b0;
      end
    end
    hw = '0;
    iw = '0;
    mw = '0;
    for (int s = salc_pkg::MAX_WAYS - 1; s >= 0; s--) begin
      if (match[s])  hw = 4'(s);
      if (inval[s])  iw = 4'(s);
      if (is_max[s]) mw = 4'(s);
    end
    hit      = |match;
    any_inv  = |inval;
    may_fill = cmd_i.ev_pf
             || !(cmd_q == salc_pkg::CMD_STORE && !cfg_i.store_miss_allocate);
    tw       = hit ? hw : (any_inv ? iw : mw);
    old_rank = hit ? {1'b0, row_in[hw].rank} : 5'd16;
    ev       = cmd_i.ev_demand || cmd_i.ev_pf;
    we       = ev && (hit || may_fill);
    row_out  = row_in;
    for (int s = 0; s < salc_pkg::MAX_WAYS; s++) begin
      if (active[s] && (4'(s) != tw) && row_in[s].valid
          && ({1'b0, row_in[s].rank} < old_rank)) begin
        row_out[s].rank = (row_in[s].rank == 4'd15) ? 4'd15 : row_in[s].rank + 4'd1;
      end
    end
    row_out[tw].valid = 1'b1;
    row_out[tw].rank  = 4'd0;
    if (!hit) row_out[tw].tag = ev_loc.tag;
  end

  assign status_o.do_pf = (cfg_i.prefetch_mode == salc_pkg::PF_EVERY)
                       || ((cfg_i.prefetch_mode == salc_pkg::PF_MISS) && !hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      hits_q      <= '0;
      acc_q       <= '0;
    end else begin
      if (clr_i) begin
        row_valid_q <= '0;
      end else if (we) begin
        row_valid_q[ev_loc.row] <= 1'b1;
      end
      if (cmd_i.ev_demand) begin
        if (acc_q != '1) acc_q <= acc_q + 32'd1;
        if (hit && hits_q != '1) hits_q <= hits_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rv_q <= row_valid_q[raddr];
    if (cmd_i.accept) begin
      cmd_q  <= in_data_i.command;
      addr_q <= in_addr;
    end
    if (cmd_i.ev_demand) hit_q <= hit;
    if (cmd_i.load_out) begin
      out_q.hit          <= hit_q;
      out_q.hit_count    <= hits_q;
      out_q.access_count <= acc_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> design/salc_checker.sv
// Port-level checks of the hit tracker, bound to the top level.
// Depends on salc_pkg and set_assoc_lru_cache_hit_tracker.
module salc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input salc_pkg::out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while an item is in flight");

  a_hits_le_accesses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hit_count <= out_data_o.access_count)
    else $error("hit count exceeds access count");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.hit_count != 32'd0)
    else $error("hit reported with zero hit count");

endmodule

bind set_assoc_lru_cache_hit_tracker salc_checker u_salc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> test/set_assoc_lru_cache_hit_tracker_test.sv
`timescale 1ns / 1ps
// Self-checking bench for set_assoc_lru_cache_hit_tracker: a directed beat table then random
// address streams per geometry, checked against a built-in LRU tag predictor. Needs salc_pkg.
module set_assoc_lru_cache_hit_tracker_test;

  localparam int NLINES    = 1024;
  localparam int MAX_CYC   = 600000;
  localparam int SETTLE    = 20;

  typedef struct packed {
    logic [3:0] csz;
    logic [2:0] wl;
    logic       alloc;
    logic [1:0] pf;
    int         idle_pct;
    int         stall_pct;
    int         beats;
  } phase_t;

  // One row of the directed table; known marks a hit flag that is obvious by hand.
  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
    logic        known;
    logic        hit;
  } row_t;

  logic       clk_i, rst_ni;
  logic       in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  salc_pkg::in_beat_t   in_data_i;
  salc_pkg::out_beat_t  out_data_o;
  logic       psel, penable, pwrite, pready;
  logic [salc_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  set_assoc_lru_cache_hit_tracker DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor copy of the tag store and registers
  logic        tag_ok  [NLINES];
  logic [31:0] tag_of  [NLINES];
  logic [3:0]  rank_of [NLINES];
  logic [31:0] hits_seen, accesses_seen;
  salc_pkg::cfg_t cfg;

  salc_pkg::out_beat_t pending_results[$];
  int          mismatches;
  int          cycles;
  int          idle_pct, stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drop every valid bit and rank, as a geometry write does
  task automatic flush_lines();
    for (int i = 0; i < NLINES; i++) begin
      tag_ok[i]  = 1'b0;
      rank_of[i] = 4'd0;
    end
  endtask

  // Make way w the youngest of its set and mark it valid
  function automatic void promote_way(input int base, input int ways, input int w);
    int oldr;
    oldr = tag_ok[base + w] ? int'(rank_of[base + w]) : 16;
    for (int v = 0; v < ways; v++)
      if (v != w && tag_ok[base + v] && int'(rank_of[base + v]) < oldr)
        rank_of[base + v] = (rank_of[base + v] < 4'd15) ? rank_of[base + v] + 4'd1 : 4'd15;
    rank_of[base + w] = 4'd0;
    tag_ok[base + w]  = 1'b1;
  endfunction

  // Look one line up; fill the free or oldest way on a miss when allowed
  function automatic logic lookup_line(input logic [31:0] a, input logic may_fill);
    int csz, wl, setbits, ways, sets, set_idx, base, victim;
    logic [31:0] t;
    csz = (cfg.cache_size_log2 < 10) ? 10 : (cfg.cache_size_log2 > 15) ? 15
        : int'(cfg.cache_size_log2);
    wl = (cfg.ways_log2 > 4) ? 4 : int'(cfg.ways_log2);
    setbits = csz - salc_pkg::LINE_SHIFT - wl;
    ways = 1 << wl;
    sets = 1 << setbits;
    set_idx = int'((a >> salc_pkg::LINE_SHIFT) & (sets - 1));
    t = a >> (salc_pkg::LINE_SHIFT + setbits);
    base = set_idx * ways;
    for (int w = 0; w < ways; w++)
      if (tag_ok[base + w] && tag_of[base + w] == t) begin
        promote_way(base, ways, w);
        return 1'b1;
      end
    if (!may_fill) return 1'b0;
    victim = ways;
    for (int w = 0; w < ways; w++)
      if (!tag_ok[base + w] && victim == ways) victim = w;
    if (victim == ways) begin
      victim = 0;
      for (int w = 1; w < ways; w++)
        if (rank_of[base + w] > rank_of[base + victim]) victim = w;
    end
    tag_ok[base + victim] = 1'b0;
    promote_way(base, ways, victim);
    tag_of[base + victim] = t;
    return 1'b0;
  endfunction

  // Work out the result beat of one accepted access
  function automatic salc_pkg::out_beat_t predict_access(input salc_pkg::in_beat_t b);
    salc_pkg::out_beat_t r;
    logic h;
    h = lookup_line(b.address,
                    !(b.command == salc_pkg::CMD_STORE && !cfg.store_miss_allocate));
    if (accesses_seen != 32'hFFFF_FFFF) accesses_seen++;
    if (h && hits_seen != 32'hFFFF_FFFF) hits_seen++;
    if (cfg.prefetch_mode == salc_pkg::PF_EVERY
        || (cfg.prefetch_mode == salc_pkg::PF_MISS && !h))
      void'(lookup_line(b.address + salc_pkg::LINE_BYTES, 1'b1));
    r.hit = h;
    r.hit_count = hits_seen;
    r.access_count = accesses_seen;
    return r;
  endfunction

  // APB write: setup cycle, access cycle, then release
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= salc_pkg::PADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      salc_pkg::REG_CACHE_SIZE:  begin cfg.cache_size_log2 = val[3:0]; flush_lines(); end
      salc_pkg::REG_WAYS:        begin cfg.ways_log2 = val[2:0]; flush_lines(); end
      salc_pkg::REG_STORE_ALLOC: cfg.store_miss_allocate = val[0];
      salc_pkg::REG_PREFETCH:    cfg.prefetch_mode = val[1:0];
      default: ;
    endcase
  endtask

  // Offer one beat, hold it until taken, and queue its expected result
  task automatic offer_beat(input logic cmd, input logic [31:0] addr,
                            output salc_pkg::out_beat_t res);
    salc_pkg::in_beat_t b;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    b.command = cmd;
    b.address = addr;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_access(b);
    pending_results = {pending_results, res};
  endtask

  // Wait for the block to go idle before touching its registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Result side: stall at random, compare every beat with the oldest expectation
  initial begin
    salc_pkg::out_beat_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data_o);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.hit !== want.hit || out_data_o.hit_count !== want.hit_count ||
              out_data_o.access_count !== want.access_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  row_t   dir_rows[$];
  phase_t phases[$];
  logic [31:0] hot[16];

  initial begin
    salc_pkg::out_beat_t res;
    logic [31:0] addr, stride_ptr;
    int          pick;
    phase_t      ph;

    cycles = 0; mismatches = 0; idle_pct = 0; stall_pct = 0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    cfg.cache_size_log2 = 4'd14; cfg.ways_log2 = 3'd1;
    cfg.store_miss_allocate = 1'b1; cfg.prefetch_mode = salc_pkg::PF_NONE;
    hits_seen = '0; accesses_seen = '0;
    flush_lines();
    for (int i = 0; i < NLINES; i++) tag_of[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset geometry: 16 KiB, two ways, 256 sets
    dir_rows = '{
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0},  // cold miss
      '{1'b0, 32'h0000_0000, 1'b1, 1'b1},  // same line again
      '{1'b0, 32'h0000_001F, 1'b1, 1'b1},  // last byte of the line
      '{1'b1, 32'h0000_2000, 1'b1, 1'b0},  // store miss, fills second way
      '{1'b0, 32'h0000_4000, 1'b1, 1'b0},  // evicts the older way
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0},
      '{1'b1, 32'h0000_2000, 1'b0, 1'b0},
      '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0},  // top of the address space
      '{1'b0, 32'hFFFF_FFE0, 1'b1, 1'b1},
      '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1},  // store hit
      '{1'b0, 32'hAAAA_AAAA, 1'b1, 1'b0},
      '{1'b1, 32'h5555_5555, 1'b1, 1'b0},
      '{1'b0, 32'hAAAA_AAAA, 1'b1, 1'b1},
      '{1'b0, 32'h0000_0020, 1'b1, 1'b0},
      '{1'b1, 32'h0000_0040, 1'b1, 1'b0}
    };
    foreach (dir_rows[i]) begin
      offer_beat(dir_rows[i].cmd, dir_rows[i].addr, res);
      if (dir_rows[i].known && res.hit !== dir_rows[i].hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected hit %b, predicted %b", i, dir_rows[i].hit, res.hit);
      end
    end
    drain();

    // Geometry and policy per phase, extremes and clamped values among them
    phases = '{
      '{4'd10, 3'd0, 1'b1, salc_pkg::PF_EVERY, 0,  0,  155},
      '{4'd15, 3'd4, 1'b0, salc_pkg::PF_MISS,  74, 0,  155},
      '{4'd12, 3'd2, 1'b1, 2'd3,               0,  74, 155},
      '{4'd9,  3'd7, 1'b0, salc_pkg::PF_EVERY, 7,  7,  155},
      '{4'd11, 3'd3, 1'b0, salc_pkg::PF_NONE,  74, 74, 155},
      '{4'd15, 3'd0, 1'b1, salc_pkg::PF_MISS,  0,  0,  155}
    };
    foreach (phases[p]) begin
      ph = phases[p];
      write_reg(salc_pkg::REG_CACHE_SIZE, 32'(ph.csz));
      write_reg(salc_pkg::REG_WAYS, 32'(ph.wl));
      write_reg(salc_pkg::REG_STORE_ALLOC, 32'(ph.alloc));
      write_reg(salc_pkg::REG_PREFETCH, 32'(ph.pf));
      idle_pct = ph.idle_pct;
      stall_pct = ph.stall_pct;
      // Hot lines crowd a few sets so that LRU eviction is exercised
      for (int k = 0; k < 16; k++)
        hot[k] = (32'($urandom_range(31)) << 15) | (32'(k % 4) << salc_pkg::LINE_SHIFT);
      stride_ptr = $urandom & 32'hFFFF_FFE0;
      for (int n = 0; n < ph.beats; n++) begin
        pick = $urandom_range(99);
        if (pick < 60)
          addr = hot[$urandom_range(15)] + (32'($urandom_range(1)) << salc_pkg::LINE_SHIFT)
               + 32'($urandom_range(31));
        else if (pick < 78) begin
          stride_ptr += salc_pkg::LINE_BYTES;
          addr = stride_ptr;
        end else if (pick < 94)
          addr = $urandom;
        else
          addr = 32'hFFFF_FF80 | 32'($urandom_range(127));
        if ($urandom_range(19) == 0)
          hot[$urandom_range(15)] = $urandom & 32'hFFFF_FFE0;
        offer_beat(1'($urandom_range(1)), addr, res);
      end
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
